[hw/rtl/codebook_scalar_quantize_pack_macros.svh]
// Assertion macros for the codebook scalar quantizer.
`ifndef CODEBOOK_SCALAR_QUANTIZE_PACK_MACROS_SVH
`define CODEBOOK_SCALAR_QUANTIZE_PACK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/csq_pkg.sv]
// Package: constants, types and BF16 compare for the scalar quantizer.
package csq_pkg;
    localparam int Dim       = 128;
    localparam int Bits      = 4;
    localparam int NumBounds = (1 << Bits) - 1;
    localparam int NumLevels = 1 << Bits;
    localparam int PerByte   = 8 / Bits;
    localparam int PosW      = (Dim > 1) ? $clog2(Dim) : 1;
    localparam int SlotW     = (PerByte > 1) ? $clog2(PerByte) + 1 : 1;
    localparam int CfgIdxW   = 3;
    localparam int CfgW      = 64;

    localparam logic [CfgIdxW-1:0] RegBounds0   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegCentroid0 = 3'd4;

    typedef logic [15:0] t_bf16;

    typedef struct packed {
        logic       last;
        logic       ready;
        logic [7:0] byte_val;
    } t_pack_status;

    // True when a > b in IEEE order; NaN on either side never compares greater.
    function automatic logic bf16_greater(input t_bf16 a, input t_bf16 b);
        logic        a_nan;
        logic        b_nan;
        logic [15:0] ka;
        logic [15:0] kb;
        a_nan = a[14:0] > 15'h7F80;
        b_nan = b[14:0] > 15'h7F80;
        ka = a[15] ? ~a : (a | 16'h8000);
        kb = b[15] ? ~b : (b | 16'h8000);
        if (a_nan || b_nan) begin
            bf16_greater = 1'b0;
        end else if (a[14:0] == 15'd0 && b[14:0] == 15'd0) begin
            bf16_greater = 1'b0;
        end else begin
            bf16_greater = ka > kb;
        end
    endfunction
endpackage

[hw/rtl/codebook_scalar_quantize_pack.sv]
// Top level: BF16 scalar quantizer with codebook lookup and index packing.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | i_valid / o_ready    | i_coordinate
//  output   | o_valid / i_ready    | o_level_index, o_centroid_value,
//           |                      | o_byte_ready, o_packed_byte, o_vector_end
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
//  One coordinate per cycle unless the consumer stalls; the result is registered.
//  The boundary compares, centroid select and packing all fit between the
//  input handshake and the result register.
//  Reset clears configuration words, packing state and vector position.
//  When the result register is held by a stalled consumer, input stalls too.
`include "codebook_scalar_quantize_pack_macros.svh"
module codebook_scalar_quantize_pack (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [15:0]                        i_coordinate,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [3:0]                         o_level_index,
    output logic [15:0]                        o_centroid_value,
    output logic                               o_byte_ready,
    output logic [7:0]                         o_packed_byte,
    output logic                               o_vector_end,
    input  logic                               i_cfg_we,
    input  logic [csq_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [csq_pkg::CfgW-1:0]           i_cfg_data
);
    logic [csq_pkg::CfgW-1:0]      r_bounds [4];
    logic [csq_pkg::CfgW-1:0]      r_cents  [4];
    logic [csq_pkg::PosW-1:0]      r_pos;
    logic [7:0]                    r_acc;
    logic [csq_pkg::SlotW-1:0]     r_slot;
    logic                          r_valid;
    logic [3:0]                    r_level;
    logic [15:0]                   r_cent;
    logic                          r_bready;
    logic [7:0]                    r_byte;
    logic                          r_vend;

    logic                          xfer_in;
    logic [csq_pkg::Bits-1:0]      level;
    logic [4*csq_pkg::CfgW-1:0]    bounds_flat;
    logic [4*csq_pkg::CfgW-1:0]    cents_flat;
    logic [csq_pkg::SlotW-1:0]     n_slot;
    logic [7:0]                    n_acc;
    logic [csq_pkg::PosW-1:0]      n_pos;
    csq_pkg::t_pack_status         pk;

    assign bounds_flat = {r_bounds[3], r_bounds[2], r_bounds[1], r_bounds[0]};
    assign cents_flat  = {r_cents[3], r_cents[2], r_cents[1], r_cents[0]};

    // Accept whenever the result register is empty or being drained.
    assign o_ready = !r_valid || i_ready;
    assign xfer_in = i_valid && o_ready;

    csq_level_find u_find (
        .i_coord  (i_coordinate),
        .i_bounds (bounds_flat),
        .o_level  (level)
    );

    // Drop the level into the next free slot and flag a full or final byte.
    always_comb begin
        n_acc   = r_acc | 8'(({4'd0, level} << (r_slot * csq_pkg::Bits)));
        n_slot  = r_slot + 1'b1;
        pk.last = (32'(r_pos) >= 32'(csq_pkg::Dim - 1));
        pk.ready = (32'(n_slot) >= 32'(csq_pkg::PerByte)) || pk.last;
        pk.byte_val = n_acc;
        n_pos = pk.last ? '0 : r_pos + 1'b1;
    end

    // Configuration words: bounds first, centroids after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_bounds[k] <= '0;
                r_cents[k]  <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index < csq_pkg::RegCentroid0) begin
                r_bounds[i_cfg_index[1:0] - csq_pkg::RegBounds0[1:0]] <= i_cfg_data;
            end else begin
                r_cents[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    // Packing state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_slot <= '0;
        end else if (xfer_in) begin
            r_pos  <= n_pos;
            r_acc  <= pk.ready ? 8'd0 : n_acc;
            r_slot <= pk.ready ? '0 : n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Result payload; hold while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (xfer_in) begin
            r_level  <= 4'(level);
            r_cent   <= cents_flat[32'(level)*16 +: 16];
            r_bready <= pk.ready;
            r_byte   <= pk.ready ? pk.byte_val : 8'd0;
            r_vend   <= pk.last;
        end
    end

    assign o_valid          = r_valid;
    assign o_level_index    = r_level;
    assign o_centroid_value = r_cent;
    assign o_byte_ready     = r_bready;
    assign o_packed_byte    = r_byte;
    assign o_vector_end     = r_vend;

    `CSQ_ASSERT_IMPL(a_vend_has_byte, i_clk, i_rst_n, o_valid && o_vector_end, o_byte_ready, "vector end without finished byte")
    `CSQ_ASSERT_IMPL(a_byte_zero_idle, i_clk, i_rst_n, o_valid && !o_byte_ready, o_packed_byte == 8'd0, "packed byte not clear")
    `CSQ_ASSERT_NEXT(a_pos_wrap, i_clk, i_rst_n, xfer_in && pk.last, r_pos == '0 && r_slot == '0, "vector end did not restart packing")
endmodule

[hw/rtl/csq_level_find.sv]
// Level search: parallel BF16 compares against all boundaries, first stop wins.
module csq_level_find (
    input  csq_pkg::t_bf16                   i_coord,
    input  logic [4*csq_pkg::CfgW-1:0]       i_bounds,
    output logic [csq_pkg::Bits-1:0]         o_level
);
    logic [csq_pkg::NumBounds-1:0] gt;

    always_comb begin
        for (int j = 0; j < csq_pkg::NumBounds; j++) begin
            gt[j] = csq_pkg::bf16_greater(i_coord, i_bounds[j*16 +: 16]);
        end
    end

    // Level is the count of leading passed boundaries.
    always_comb begin
        logic stop;
        stop    = 1'b0;
        o_level = '0;
        for (int j = 0; j < csq_pkg::NumBounds; j++) begin
            if (!stop && gt[j]) begin
                o_level = csq_pkg::Bits'(j + 1);
            end else begin
                stop = 1'b1;
            end
        end
    end
endmodule
